/* design/v3alu_pkg.sv */
package v3alu_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_NEG   = 4'd2;
    localparam logic [3:0] OP_SCALE = 4'd3;
    localparam logic [3:0] OP_DIV   = 4'd4;
    localparam logic [3:0] OP_CROSS = 4'd5;
    localparam logic [3:0] OP_DOT   = 4'd6;
    localparam logic [3:0] OP_MAG   = 4'd7;
    localparam logic [3:0] OP_NORM  = 4'd8;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;
    localparam logic [1:0] ST_ZERO = 2'd3;

    localparam logic [31:0] POS_LIM = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIM = 32'h8000_0000;

    // Item state carried down the pipe
    typedef struct packed {
        logic [3:0]       op;
        logic [2:0][31:0] res;
        logic [1:0]       st;
        logic             eq;
        logic [2:0][31:0] mag;   // |a_i|
        logic [2:0]       aneg;  // a_i < 0
        logic [2:0]       qneg;  // sign of the quotient
        logic [31:0]      dvs;   // divisor, later the root
    } t_item;

endpackage

/* design/v3alu_front.sv */
module v3alu_front #(
    parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [3:0]          i_op,
    input  logic signed [31:0]  i_a_x,
    input  logic signed [31:0]  i_a_y,
    input  logic signed [31:0]  i_a_z,
    input  logic signed [31:0]  i_b_x,
    input  logic signed [31:0]  i_b_y,
    input  logic signed [31:0]  i_b_z,
    input  logic signed [31:0]  i_s,
    output logic                o_vld,
    output v3alu_pkg::t_item    o_item,
    output logic [63:0]         o_sumsq
);
    import v3alu_pkg::*;

    localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] MAXV = 66'sd2147483647;
    localparam logic signed [65:0] MINV = -66'sd2147483648;

    function automatic logic signed [65:0] f_rnd(input logic signed [65:0] v);
        f_rnd = (v + HALF) >>> FRAC_BITS;
    endfunction

    function automatic logic [32:0] f_sat(input logic signed [65:0] v);
        if (v > MAXV) begin
            f_sat = {1'b1, POS_LIM};
        end else if (v < MINV) begin
            f_sat = {1'b1, NEG_LIM};
        end else begin
            f_sat = {1'b0, v[31:0]};
        end
    endfunction

    // stage 1: operand select
    logic               r1_vld, r2_vld, r3_vld;
    logic [3:0]         r1_op, r2_op;
    logic               r1_eq, r2_eq;
    logic signed [31:0] r1_a [3];
    logic signed [31:0] r1_b [3];
    logic signed [31:0] r1_s;
    logic signed [31:0] r1_mx [6];
    logic signed [31:0] r1_my [6];
    logic signed [31:0] n1_mx [6];
    logic signed [31:0] n1_my [6];
    // stage 2: products
    logic signed [31:0] r2_a [3];
    logic signed [31:0] r2_b [3];
    logic signed [31:0] r2_s;
    logic signed [63:0] r2_p [6];
    // stage 3: combine
    t_item              r3_item, n3_item;
    logic [63:0]        r3_sumsq, n3_sumsq;

    always_comb begin
        n1_mx[3] = i_a_x; n1_my[3] = i_b_z;
        n1_mx[4] = i_a_x; n1_my[4] = i_b_y;
        n1_mx[5] = i_a_y; n1_my[5] = i_b_x;
        unique case (i_op)
            OP_SCALE: begin
                n1_mx[0] = i_a_x; n1_my[0] = i_s;
                n1_mx[1] = i_a_y; n1_my[1] = i_s;
                n1_mx[2] = i_a_z; n1_my[2] = i_s;
            end
            OP_DOT: begin
                n1_mx[0] = i_a_x; n1_my[0] = i_b_x;
                n1_mx[1] = i_a_y; n1_my[1] = i_b_y;
                n1_mx[2] = i_a_z; n1_my[2] = i_b_z;
            end
            OP_CROSS: begin
                n1_mx[0] = i_a_y; n1_my[0] = i_b_z;
                n1_mx[1] = i_a_z; n1_my[1] = i_b_y;
                n1_mx[2] = i_a_z; n1_my[2] = i_b_x;
            end
            default: begin
                // squares for magnitude and normalize
                n1_mx[0] = i_a_x; n1_my[0] = i_a_x;
                n1_mx[1] = i_a_y; n1_my[1] = i_a_y;
                n1_mx[2] = i_a_z; n1_my[2] = i_a_z;
            end
        endcase
    end

    always_comb begin
        logic signed [65:0] v [3];
        logic [32:0]        sv;
        logic               any_sat;
        n3_item    = '0;
        n3_item.op = r2_op;
        n3_item.eq = r2_eq;
        n3_item.st = ST_OK;
        n3_item.dvs = r2_s[31] ? 32'(-r2_s) : 32'(r2_s);
        any_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            v[i] = '0;
            n3_item.aneg[i] = r2_a[i][31];
            n3_item.qneg[i] = r2_a[i][31] ^ ((r2_op == OP_DIV) && r2_s[31]);
            n3_item.mag[i]  = r2_a[i][31] ? 32'(-r2_a[i]) : 32'(r2_a[i]);
        end
        unique case (r2_op)
            OP_ADD: begin
                for (int i = 0; i < 3; i++) v[i] = 66'(r2_a[i]) + 66'(r2_b[i]);
            end
            OP_SUB: begin
                for (int i = 0; i < 3; i++) v[i] = 66'(r2_a[i]) - 66'(r2_b[i]);
            end
            OP_NEG: begin
                for (int i = 0; i < 3; i++) v[i] = -66'(r2_a[i]);
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) v[i] = f_rnd(66'(r2_p[i]));
            end
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    v[i] = f_rnd(66'(r2_p[2*i]) - 66'(r2_p[2*i+1]));
                end
            end
            OP_DOT: begin
                v[0] = f_rnd(66'(r2_p[0]) + 66'(r2_p[1]) + 66'(r2_p[2]));
            end
            default: begin
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            sv = f_sat(v[i]);
            n3_item.res[i] = sv[31:0];
            any_sat = any_sat | sv[32];
        end
        if (any_sat) begin
            n3_item.st = ST_SAT;
        end
        // divide by zero resolves here; a nonzero divisor finishes downstream
        if (r2_op == OP_DIV && r2_s == 32'sd0) begin
            n3_item.st = ST_DIV0;
            for (int i = 0; i < 3; i++) begin
                if (r2_a[i][31]) begin
                    n3_item.res[i] = NEG_LIM;
                end else if (r2_a[i] != 32'sd0) begin
                    n3_item.res[i] = POS_LIM;
                end else begin
                    n3_item.res[i] = '0;
                end
            end
        end
        n3_sumsq = 64'(r2_p[0]) + 64'(r2_p[1]) + 64'(r2_p[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op <= i_op;
            r1_eq <= (i_a_x == i_b_x) && (i_a_y == i_b_y) && (i_a_z == i_b_z);
            r1_a[0] <= i_a_x; r1_a[1] <= i_a_y; r1_a[2] <= i_a_z;
            r1_b[0] <= i_b_x; r1_b[1] <= i_b_y; r1_b[2] <= i_b_z;
            r1_s <= i_s;
            for (int j = 0; j < 6; j++) begin
                r1_mx[j] <= n1_mx[j];
                r1_my[j] <= n1_my[j];
            end
            r2_op <= r1_op;
            r2_eq <= r1_eq;
            r2_a  <= r1_a;
            r2_b  <= r1_b;
            r2_s  <= r1_s;
            for (int j = 0; j < 6; j++) begin
                r2_p[j] <= 64'(r1_mx[j]) * 64'(r1_my[j]);
            end
            r3_item  <= n3_item;
            r3_sumsq <= n3_sumsq;
        end
    end

    assign o_vld   = r3_vld;
    assign o_item  = r3_item;
    assign o_sumsq = r3_sumsq;

endmodule

/* design/v3alu_sqrt.sv */
module v3alu_sqrt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  v3alu_pkg::t_item i_item,
    input  logic [63:0]      i_n,
    output logic             o_vld,
    output v3alu_pkg::t_item o_item,
    output logic [31:0]      o_root
);
    import v3alu_pkg::*;

    localparam int STAGES = 32;

    // one result bit per stage, two radicand bits consumed
    logic [STAGES-1:0] r_vld;
    t_item             r_item [STAGES];
    logic [31:0]       r_root [STAGES];
    logic [34:0]       r_rem  [STAGES];
    logic [63:0]       r_n    [STAGES];
    logic [31:0]       n_root [STAGES];
    logic [34:0]       n_rem  [STAGES];
    logic [63:0]       n_n    [STAGES];

    always_comb begin
        logic [31:0] p_root;
        logic [34:0] p_rem;
        logic [63:0] p_n;
        logic [34:0] rem_sh;
        logic [34:0] trial;
        for (int k = 0; k < STAGES; k++) begin
            if (k == 0) begin
                p_root = '0;
                p_rem  = '0;
                p_n    = i_n;
            end else begin
                p_root = r_root[k-1];
                p_rem  = r_rem[k-1];
                p_n    = r_n[k-1];
            end
            rem_sh = {p_rem[32:0], p_n[63:62]};
            trial  = {1'b0, p_root, 2'b01};
            if (rem_sh >= trial) begin
                n_rem[k]  = rem_sh - trial;
                n_root[k] = {p_root[30:0], 1'b1};
            end else begin
                n_rem[k]  = rem_sh;
                n_root[k] = {p_root[30:0], 1'b0};
            end
            n_n[k] = p_n << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item[0] <= i_item;
            for (int k = 1; k < STAGES; k++) r_item[k] <= r_item[k-1];
            for (int k = 0; k < STAGES; k++) begin
                r_root[k] <= n_root[k];
                r_rem[k]  <= n_rem[k];
                r_n[k]    <= n_n[k];
            end
        end
    end

    assign o_vld  = r_vld[STAGES-1];
    assign o_item = r_item[STAGES-1];
    assign o_root = r_root[STAGES-1];

endmodule

/* design/v3alu_div.sv */
module v3alu_div #(
    parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  v3alu_pkg::t_item i_item,
    input  logic [31:0]      i_root,
    output logic             o_vld,
    output v3alu_pkg::t_item o_item
);
    import v3alu_pkg::*;

    localparam int STAGES = 32;

    // prep stage
    logic             rp_vld;
    t_item            rp_item, np_item;
    logic [2:0][31:0] rp_r, np_r;
    logic [2:0][31:0] rp_l, np_l;
    logic [2:0]       rp_ovf, np_ovf;
    // restoring divider, one quotient bit per stage
    logic [STAGES-1:0] r_vld;
    t_item             r_item [STAGES];
    logic [2:0][31:0]  r_r    [STAGES];
    logic [2:0][31:0]  r_l    [STAGES];
    logic [2:0][31:0]  r_q    [STAGES];
    logic [2:0]        r_ovf  [STAGES];
    logic [2:0][31:0]  n_r    [STAGES];
    logic [2:0][31:0]  n_l    [STAGES];
    logic [2:0][31:0]  n_q    [STAGES];
    // final stage
    logic              rf_vld;
    t_item             rf_item, nf_item;

    always_comb begin
        logic [31:0] r0;
        np_item = i_item;
        if (i_item.op == OP_MAG || i_item.op == OP_NORM) begin
            np_item.dvs = i_root;
        end
        for (int i = 0; i < 3; i++) begin
            // numerator is |a| << FRAC_BITS; r0 is its part above bit 31
            r0        = i_item.mag[i] >> (32 - FRAC_BITS);
            np_l[i]   = i_item.mag[i] << FRAC_BITS;
            np_ovf[i] = r0 >= np_item.dvs;
            np_r[i]   = np_ovf[i] ? '0 : r0;
        end
    end

    always_comb begin
        logic [2:0][31:0] p_r;
        logic [2:0][31:0] p_l;
        logic [2:0][31:0] p_q;
        logic [31:0]      d;
        logic [32:0]      t;
        for (int k = 0; k < STAGES; k++) begin
            if (k == 0) begin
                p_r = rp_r;
                p_l = rp_l;
                p_q = '0;
                d   = rp_item.dvs;
            end else begin
                p_r = r_r[k-1];
                p_l = r_l[k-1];
                p_q = r_q[k-1];
                d   = r_item[k-1].dvs;
            end
            for (int i = 0; i < 3; i++) begin
                t = {p_r[i], p_l[i][31]};
                if (t >= {1'b0, d}) begin
                    n_r[k][i] = 32'(t - {1'b0, d});
                    n_q[k][i] = {p_q[i][30:0], 1'b1};
                end else begin
                    n_r[k][i] = t[31:0];
                    n_q[k][i] = {p_q[i][30:0], 1'b0};
                end
                n_l[k][i] = p_l[i] << 1;
            end
        end
    end

    always_comb begin
        t_item            it;
        logic [2:0][31:0] q;
        logic [2:0]       ovf;
        logic             sat;
        logic             any_sat;
        it  = r_item[STAGES-1];
        q   = r_q[STAGES-1];
        ovf = r_ovf[STAGES-1];
        nf_item = it;
        any_sat = 1'b0;
        unique case (it.op)
            OP_DIV: begin
                if (it.st != ST_DIV0) begin
                    for (int i = 0; i < 3; i++) begin
                        sat = ovf[i] | (it.qneg[i] ? (q[i] > NEG_LIM) : q[i][31]);
                        any_sat = any_sat | sat;
                        if (sat) begin
                            nf_item.res[i] = it.qneg[i] ? NEG_LIM : POS_LIM;
                        end else begin
                            nf_item.res[i] = it.qneg[i] ? 32'(-q[i]) : q[i];
                        end
                    end
                    nf_item.st = any_sat ? ST_SAT : ST_OK;
                end
            end
            OP_MAG: begin
                nf_item.res[0] = it.dvs[31] ? POS_LIM : it.dvs;
                nf_item.st     = it.dvs[31] ? ST_SAT : ST_OK;
            end
            OP_NORM: begin
                if (it.dvs == '0) begin
                    // zero-length vector goes back unchanged
                    for (int i = 0; i < 3; i++) begin
                        nf_item.res[i] = it.aneg[i] ? 32'(-it.mag[i]) : it.mag[i];
                    end
                    nf_item.st = ST_ZERO;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        nf_item.res[i] = it.qneg[i] ? 32'(-q[i]) : q[i];
                    end
                    nf_item.st = ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rp_vld <= 1'b0;
            r_vld  <= '0;
            rf_vld <= 1'b0;
        end else if (i_en) begin
            rp_vld <= i_vld;
            r_vld  <= {r_vld[STAGES-2:0], rp_vld};
            rf_vld <= r_vld[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rp_item <= np_item;
            rp_r    <= np_r;
            rp_l    <= np_l;
            rp_ovf  <= np_ovf;
            r_item[0] <= rp_item;
            r_ovf[0]  <= rp_ovf;
            for (int k = 1; k < STAGES; k++) begin
                r_item[k] <= r_item[k-1];
                r_ovf[k]  <= r_ovf[k-1];
            end
            for (int k = 0; k < STAGES; k++) begin
                r_r[k] <= n_r[k];
                r_l[k] <= n_l[k];
                r_q[k] <= n_q[k];
            end
            rf_item <= nf_item;
        end
    end

    assign o_vld  = rf_vld;
    assign o_item = rf_item;

endmodule

/* design/vector3_alu.sv */
// vector3_alu: three-component Q-format vector unit.
// Pipeline: 3 front-end stages, 32 square-root stages, 1 divisor-select stage,
// 32 divider stages, 1 output stage. Throughput: one transaction per cycle
// unless the output stalls; the long pole is the bit-per-stage square root
// followed by the bit-per-stage divider, both fully pipelined.
// Reset (i_rst_n low, synchronous) clears only the valid bits of every stage.
module vector3_alu #(
    parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [3:0]         i_operation,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    input  logic signed [31:0] i_scalar,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_res_x,
    output logic signed [31:0] o_res_y,
    output logic signed [31:0] o_res_z,
    output logic [1:0]         o_status,
    output logic               o_vectors_equal
);
    import v3alu_pkg::*;

    // The whole pipe advances together. It holds only while a finished
    // result sits in the output register and the sink does not take it,
    // so a stall neither drops nor repeats a transaction.
    logic        pipe_en;
    logic        front_vld, sqrt_vld, div_vld;
    t_item       front_item, sqrt_item, div_item;
    logic [63:0] front_sumsq;
    logic [31:0] sqrt_root;

    assign pipe_en = !div_vld || i_ready;
    assign o_ready = pipe_en;

    // Operand select, six 32x32 multipliers, then add/sub/negate, rounding
    // of scale/cross/dot, saturation and the sum of squares.
    v3alu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (i_valid),
        .i_op    (i_operation),
        .i_a_x   (i_a_x),
        .i_a_y   (i_a_y),
        .i_a_z   (i_a_z),
        .i_b_x   (i_b_x),
        .i_b_y   (i_b_y),
        .i_b_z   (i_b_z),
        .i_s     (i_scalar),
        .o_vld   (front_vld),
        .o_item  (front_item),
        .o_sumsq (front_sumsq)
    );

    // Floor square root of the 64-bit sum of squares.
    v3alu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (front_vld),
        .i_item  (front_item),
        .i_n     (front_sumsq),
        .o_vld   (sqrt_vld),
        .o_item  (sqrt_item),
        .o_root  (sqrt_root)
    );

    // Shared divider: |a| << FRAC_BITS over |scalar| (divide) or over the
    // root (normalize), plus the final sign, saturation and status.
    v3alu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (sqrt_vld),
        .i_item  (sqrt_item),
        .i_root  (sqrt_root),
        .o_vld   (div_vld),
        .o_item  (div_item)
    );

    assign o_valid         = div_vld;
    assign o_res_x         = div_item.res[0];
    assign o_res_y         = div_item.res[1];
    assign o_res_z         = div_item.res[2];
    assign o_status        = div_item.st;
    assign o_vectors_equal = div_item.eq;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

// Testbench for vector3_alu: randomized valid/ready traffic on both channels,
// an in-order scoreboard fed by a bit-exact predictor, one long receiver stall.
module tb_top;
    import v3alu_pkg::*;

    localparam int FB          = FRAC_BITS_DEF;
    localparam int N_RANDOM    = 1250;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 150;   // longer than the pipeline latency

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] ax, ay, az, bx, by, bz, sc;
    } t_vec_req;

    typedef struct packed {
        logic [31:0] rx, ry, rz;
        logic [1:0]  st;
        logic        eq;
    } t_vec_res;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [3:0]         i_operation = '0;
    logic signed [31:0] i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic signed [31:0] i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic signed [31:0] i_scalar = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_res_x, o_res_y, o_res_z;
    logic [1:0]         o_status;
    logic               o_vectors_equal;

    vector3_alu u_dut (.*);

    always #10 i_clk = ~i_clk;

    t_vec_req pending_q[$];     // transactions not yet offered
    t_vec_res expected_q[$];    // predicted results, oldest first
    int       n_fail = 0;
    int       cycle_cnt = 0;
    logic     long_hold = 1'b0;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic logic [31:0] clamp32(input logic signed [95:0] v,
                                            inout logic [1:0] st);
        if (v > 96'sh7FFF_FFFF) begin
            st = ST_SAT;
            return POS_LIM;
        end
        if (v < -96'sh8000_0000) begin
            st = ST_SAT;
            return NEG_LIM;
        end
        return v[31:0];
    endfunction

    // floor(sqrt(n)), digit by digit
    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // round to nearest, ties toward +inf, then saturate
    function automatic logic [31:0] round_clamp(input logic signed [95:0] p,
                                                inout logic [1:0] st);
        return clamp32((p + (96'sd1 <<< (FB - 1))) >>> FB, st);
    endfunction

    function automatic t_vec_res predict_vec(input t_vec_req t);
        logic signed [95:0] a[3], b[3], s;
        logic [63:0]        ua[3], sum, m, q;
        logic [31:0]        r[3];
        logic [1:0]         st;
        t_vec_res           e;
        a[0] = $signed(t.ax); a[1] = $signed(t.ay); a[2] = $signed(t.az);
        b[0] = $signed(t.bx); b[1] = $signed(t.by); b[2] = $signed(t.bz);
        s = $signed(t.sc);
        st = ST_OK;
        r[0] = 0; r[1] = 0; r[2] = 0;
        for (int i = 0; i < 3; i++) ua[i] = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
        case (t.op)
            OP_ADD: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] + b[i], st);
            OP_SUB: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] - b[i], st);
            OP_NEG: for (int i = 0; i < 3; i++) r[i] = clamp32(-a[i], st);
            OP_SCALE: for (int i = 0; i < 3; i++) r[i] = round_clamp(a[i] * s, st);
            OP_DIV: begin
                if (s == 0) begin
                    // divide by zero: signed limit per component
                    for (int i = 0; i < 3; i++)
                        r[i] = (a[i] > 0) ? POS_LIM : ((a[i] < 0) ? NEG_LIM : 32'd0);
                    st = ST_DIV0;
                end else begin
                    for (int i = 0; i < 3; i++) r[i] = clamp32((a[i] <<< FB) / s, st);
                end
            end
            OP_CROSS: for (int i = 0; i < 3; i++)
                r[i] = round_clamp(a[(i+1)%3] * b[(i+2)%3] - a[(i+2)%3] * b[(i+1)%3], st);
            OP_DOT: r[0] = round_clamp(a[0]*b[0] + a[1]*b[1] + a[2]*b[2], st);
            OP_MAG, OP_NORM: begin
                sum = ua[0]*ua[0] + ua[1]*ua[1] + ua[2]*ua[2];
                m = int_sqrt(sum);
                if (t.op == OP_MAG) begin
                    if (m > 64'h7FFF_FFFF) begin
                        r[0] = POS_LIM;
                        st = ST_SAT;
                    end else begin
                        r[0] = m[31:0];
                    end
                end else if (m == 0) begin
                    // zero-length vector passes through
                    for (int i = 0; i < 3; i++) r[i] = a[i][31:0];
                    st = ST_ZERO;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        q = (ua[i] << FB) / m;
                        r[i] = (a[i] < 0) ? -q[31:0] : q[31:0];
                    end
                end
            end
            default: ;
        endcase
        e.rx = r[0]; e.ry = r[1]; e.rz = r[2];
        e.st = st;
        e.eq = (t.ax == t.bx) && (t.ay == t.by) && (t.az == t.bz);
        return e;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic [31:0] pick_comp();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3, 4:    return $urandom_range(0, 1) ? $urandom_range(0, 1 << 18)
                                                  : -$urandom_range(0, 1 << 18);
            5:       return $urandom_range(0, 1) ? $urandom_range(0, 1 << 26)
                                                  : -$urandom_range(0, 1 << 26);
            6: case ($urandom_range(0, 4))
                   0: return POS_LIM;
                   1: return NEG_LIM;
                   2: return 32'd0;
                   3: return 32'd1;
                   default: return 32'hFFFF_FFFF;
               endcase
            7:       return 32'd0;
            default: return $urandom_range(0, 1) ? 32'h0001_0000 * $urandom_range(0, 40)
                                                  : -(32'h0001_0000 * $urandom_range(0, 40));
        endcase
    endfunction

    function automatic t_vec_req rand_req();
        t_vec_req t;
        t.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
        t.ax = pick_comp(); t.ay = pick_comp(); t.az = pick_comp();
        t.bx = pick_comp(); t.by = pick_comp(); t.bz = pick_comp();
        t.sc = pick_comp();
        case ($urandom_range(0, 9))
            0: begin            // equal vectors
                t.bx = t.ax; t.by = t.ay; t.bz = t.az;
            end
            1: begin            // one component off
                t.bx = t.ax; t.by = t.ay; t.bz = t.az ^ (32'd1 << $urandom_range(0, 31));
            end
            2: if (t.op == OP_NORM || t.op == OP_MAG) begin
                t.ax = 0; t.ay = 0; t.az = 0;
            end
            default: ;
        endcase
        return t;
    endfunction

    function automatic t_vec_req mk_req(input logic [3:0] op,
                                        input logic [31:0] ax, ay, az, bx, by, bz, sc);
        t_vec_req t;
        t.op = op; t.ax = ax; t.ay = ay; t.az = az;
        t.bx = bx; t.by = by; t.bz = bz; t.sc = sc;
        return t;
    endfunction

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------------------------------------------------------
    // Driver
    // ---------------------------------------------------------------
    t_vec_req cur_req;
    int       src_gap = 0;
    logic     stim_done = 1'b0;

    always @(posedge i_clk) begin
        t_vec_req t;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) expected_q.push_back(predict_vec(cur_req));
            if (!i_valid || o_ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    i_valid <= 1'b0;
                end else if (stim_done && pending_q.size() > 0) begin
                    t = pending_q.pop_front();
                    cur_req     <= t;
                    i_operation <= t.op;
                    i_a_x <= t.ax; i_a_y <= t.ay; i_a_z <= t.az;
                    i_b_x <= t.bx; i_b_y <= t.by; i_b_z <= t.bz;
                    i_scalar <= t.sc;
                    i_valid <= 1'b1;
                    src_gap <= rand_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor / scoreboard
    // ---------------------------------------------------------------
    int sink_gap = 0;

    always @(posedge i_clk) begin
        t_vec_res e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $error("result transaction with nothing expected");
                n_fail++;
            end else begin
                e = expected_q.pop_front();
                if (o_res_x !== e.rx) begin
                    $error("res_x expected %h actual %h", e.rx, o_res_x);
                    n_fail++;
                end
                if (o_res_y !== e.ry) begin
                    $error("res_y expected %h actual %h", e.ry, o_res_y);
                    n_fail++;
                end
                if (o_res_z !== e.rz) begin
                    $error("res_z expected %h actual %h", e.rz, o_res_z);
                    n_fail++;
                end
                if (o_status !== e.st) begin
                    $error("status expected %0d actual %0d", e.st, o_status);
                    n_fail++;
                end
                if (o_vectors_equal !== e.eq) begin
                    $error("vectors_equal expected %0d actual %0d", e.eq, o_vectors_equal);
                    n_fail++;
                end
            end
        end
        // random backpressure, overridden by the long hold
        if (long_hold) begin
            i_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) sink_gap <= rand_gap();
        end
    end

    // long receiver stall so the pipe fills and o_ready drops
    always @(posedge i_clk) begin
        if (cycle_cnt == 2000) long_hold <= 1'b1;
        else if (cycle_cnt == 2400) long_hold <= 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        // directed corners
        pending_q.push_back(mk_req(OP_ADD, POS_LIM, NEG_LIM, 1, POS_LIM, NEG_LIM, -1, 0));
        pending_q.push_back(mk_req(OP_SUB, POS_LIM, NEG_LIM, 0, NEG_LIM, POS_LIM, 0, 0));
        pending_q.push_back(mk_req(OP_NEG, NEG_LIM, POS_LIM, 0, 0, 0, 0, 0));
        pending_q.push_back(mk_req(OP_SCALE, POS_LIM, NEG_LIM, 32'h0001_8000,
                                   0, 0, 0, POS_LIM));
        pending_q.push_back(mk_req(OP_SCALE, 32'h8000, -32'h8000, 3, 0, 0, 0, 1));
        pending_q.push_back(mk_req(OP_DIV, 5, -5, 0, 0, 0, 0, 0));
        pending_q.push_back(mk_req(OP_DIV, NEG_LIM, POS_LIM, 32'h0001_0000,
                                   0, 0, 0, 32'hFFFF_FFFF));
        pending_q.push_back(mk_req(OP_DIV, 32'h0003_0000, -7, 1, 0, 0, 0, 32'h0002_0000));
        pending_q.push_back(mk_req(OP_CROSS, POS_LIM, NEG_LIM, POS_LIM,
                                   NEG_LIM, POS_LIM, NEG_LIM, 0));
        pending_q.push_back(mk_req(OP_CROSS, NEG_LIM, NEG_LIM, NEG_LIM,
                                   NEG_LIM, POS_LIM, NEG_LIM, 0));
        pending_q.push_back(mk_req(OP_CROSS, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0));
        pending_q.push_back(mk_req(OP_DOT, NEG_LIM, NEG_LIM, NEG_LIM,
                                   NEG_LIM, NEG_LIM, NEG_LIM, 0));
        pending_q.push_back(mk_req(OP_DOT, 32'h8000, 1, -1, 1, 32'h8000, 32'h8000, 0));
        pending_q.push_back(mk_req(OP_MAG, NEG_LIM, NEG_LIM, NEG_LIM, 0, 0, 0, 0));
        pending_q.push_back(mk_req(OP_MAG, 3, 4, 0, 3, 4, 0, 0));
        pending_q.push_back(mk_req(OP_NORM, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(mk_req(OP_NORM, NEG_LIM, POS_LIM, 1, 0, 0, 0, 0));
        pending_q.push_back(mk_req(OP_NORM, -32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0));
        pending_q.push_back(mk_req(4'd9, 1, 2, 3, 1, 2, 3, 4));
        pending_q.push_back(mk_req(4'd15, POS_LIM, POS_LIM, POS_LIM,
                                   POS_LIM, POS_LIM, POS_LIM, POS_LIM));
        pending_q.push_back(mk_req(4'd12, NEG_LIM, 0, 0, NEG_LIM, 0, 1, NEG_LIM));
        for (int k = 0; k < N_RANDOM; k++) pending_q.push_back(rand_req());

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        stim_done <= 1'b1;

        wait (pending_q.size() == 0 && !i_valid);
        wait (expected_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (n_fail == 0 && expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/v3alu_pkg.sv
design/v3alu_front.sv
design/v3alu_sqrt.sv
design/v3alu_div.sv
design/vector3_alu.sv
tb/sv/tb_top.sv
